@@ rtl/bsp_pkg.sv @@
// Shared types, constants and a saturating helper function for the box support point block.
package bsp_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_MIN_X = 3'd0,
        CFG_MIN_Y = 3'd1,
        CFG_MIN_Z = 3'd2,
        CFG_MAX_X = 3'd3,
        CFG_MAX_Y = 3'd4,
        CFG_MAX_Z = 3'd5
    } cfg_reg_t;

    // Operation issued to the shared multiplier
    typedef enum logic [2:0] {
        MUL_NONE = 3'd0,
        MUL_Q    = 3'd1,
        MUL_ROT  = 3'd2,
        MUL_DOT  = 3'd3,
        MUL_SQ   = 3'd4,
        MUL_NUM  = 3'd5
    } mul_op_t;

    // Sequence lengths
    localparam int Q_PRODUCTS = 10;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 34;

    // Quaternion component pairs: ww xx yy zz xy wz xz wy yz wx (w=0 x=1 y=2 z=3)
    localparam logic [1:0] QA [Q_PRODUCTS] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1,
                                               2'd0, 2'd1, 2'd0, 2'd2, 2'd0};
    localparam logic [1:0] QB [Q_PRODUCTS] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd2,
                                               2'd3, 2'd3, 2'd2, 2'd3, 2'd1};

    // Corner order; bit j set selects the maximum on axis j
    localparam logic [2:0] CORNER_SEL [8] = '{3'b000, 3'b001, 3'b010, 3'b100,
                                              3'b111, 3'b110, 3'b101, 3'b011};

    // One query word
    typedef struct packed {
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [31:0] bias;
    } query_t;

    // One result word
    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } point_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       load;
        mul_op_t    mul;
        logic [3:0] k;
        logic [1:0] i;
        logic [1:0] j;
        logic [2:0] corner;
        logic       comb;
        logic       shift;
        logic       sqrt_step;
        logic [4:0] sqrt_k;
        logic       div_step;
        logic       apply;
        logic       emit;
    } bsp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic zero_dir;
        logic norm_ok;
    } bsp_status_t;

    // Saturate a wide signed value to the 32-bit signed range
    function automatic logic signed [31:0] sat32(input logic signed [47:0] a);
        logic signed [47:0] hi_lim;
        logic signed [47:0] lo_lim;
        hi_lim = 48'sh0000_7FFF_FFFF;
        lo_lim = -48'sh0000_8000_0000;
        if (a > hi_lim)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (a < lo_lim)
        begin
            return -32'sh8000_0000;
        end
        return a[31:0];
    endfunction

endpackage

@@ rtl/bsp_query_if.sv @@
// Query and result channel interfaces of the box support point block.
interface bsp_query_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [31:0] bias;

    modport source (output valid, dir_x, dir_y, dir_z, pos_x, pos_y, pos_z,
                    quat_w, quat_x, quat_y, quat_z, bias, input ready);
    modport sink (input valid, dir_x, dir_y, dir_z, pos_x, pos_y, pos_z,
                  quat_w, quat_x, quat_y, quat_z, bias, output ready);
endinterface

interface bsp_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;

    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

@@ rtl/bsp_ctrl.sv @@
// Sequencing state machine of the box support point block.
module bsp_ctrl
    import bsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  bsp_status_t status,
    output bsp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_QUAT, S_COMB, S_ROT, S_DOT, S_SHIFT, S_SQ,
        S_SQRT, S_NUM, S_DIV, S_APPLY, S_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [1:0] i_reg, i_next;
    logic [1:0] j_reg, j_next;
    logic [2:0] corner_reg, corner_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and command decode
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        corner_next    = corner_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.mul        = MUL_NONE;
        cmd.i          = i_reg;
        cmd.j          = j_reg;
        cmd.corner     = corner_reg;
        cmd.k          = cnt_reg[3:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_QUAT;
                end
            end
            S_QUAT:
            begin
                cmd.mul = MUL_Q;
                if (cnt_reg == 6'(Q_PRODUCTS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_COMB;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            S_COMB:
            begin
                // With the count at zero, waits for the last product to land
                if (cnt_reg == 6'd0)
                begin
                    cnt_next = 6'd1;
                end
                else
                begin
                    cmd.comb    = 1'b1;
                    i_next      = '0;
                    j_next      = '0;
                    corner_next = '0;
                    state_next  = S_ROT;
                end
            end
            S_ROT:
            begin
                cmd.mul = MUL_ROT;
                if (j_reg == 2'd2)
                begin
                    j_next = '0;
                    if (i_reg == 2'd2)
                    begin
                        i_next     = '0;
                        state_next = S_DOT;
                    end
                    else
                    begin
                        i_next = i_reg + 2'd1;
                    end
                end
                else
                begin
                    j_next = j_reg + 2'd1;
                end
            end
            S_DOT:
            begin
                cmd.mul = MUL_DOT;
                if (i_reg == 2'd2)
                begin
                    i_next = '0;
                    if (corner_reg == 3'd7)
                    begin
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        corner_next = corner_reg + 3'd1;
                        state_next  = S_ROT;
                    end
                end
                else
                begin
                    i_next = i_reg + 2'd1;
                end
            end
            S_SHIFT:
            begin
                if (status.zero_dir)
                begin
                    state_next = S_FINISH;
                end
                else if (status.norm_ok)
                begin
                    i_next     = '0;
                    state_next = S_SQ;
                end
                else
                begin
                    cmd.shift = 1'b1;
                end
            end
            S_SQ:
            begin
                cmd.mul = MUL_SQ;
                if (i_reg == 2'd2)
                begin
                    i_next     = '0;
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
                else
                begin
                    i_next = i_reg + 2'd1;
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_k = 5'(6'(SQRT_STEPS) - cnt_reg);
                if (cnt_reg != 6'd0)
                begin
                    cmd.sqrt_step = 1'b1;
                end
                if (cnt_reg == 6'(SQRT_STEPS))
                begin
                    state_next = S_NUM;
                end
                cnt_next = cnt_reg + 6'd1;
            end
            S_NUM:
            begin
                cmd.mul    = MUL_NUM;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (cnt_reg != 6'd0)
                begin
                    cmd.div_step = 1'b1;
                end
                if (cnt_reg == 6'(DIV_STEPS))
                begin
                    state_next = S_APPLY;
                end
                cnt_next = cnt_reg + 6'd1;
            end
            S_APPLY:
            begin
                cmd.apply = 1'b1;
                if (i_reg == 2'd2)
                begin
                    i_next     = '0;
                    state_next = S_FINISH;
                end
                else
                begin
                    i_next     = i_reg + 2'd1;
                    state_next = S_NUM;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            corner_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            corner_reg    <= corner_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/bsp_datapath.sv @@
// Datapath with the shared multiplier, square root and divider steps.
module bsp_datapath
    import bsp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  query_t       query_word,
    input  bsp_cmd_t     cmd,
    output bsp_status_t  status,
    output point_t       result_word
);

    // Configuration and captured query
    logic signed [31:0] lo_reg [3];
    logic signed [31:0] hi_reg [3];
    logic signed [31:0] dir_reg [3];
    logic signed [31:0] pos_reg [3];
    logic signed [15:0] q_reg [4];
    logic        [31:0] ad_reg [3];
    logic        [31:0] ab_reg;
    logic               bias_neg_reg;

    // Working registers
    logic signed [31:0] qp_reg [Q_PRODUCTS];
    logic signed [26:0] r_reg [9];
    logic signed [65:0] prod_reg;
    bsp_cmd_t           cmd_d_reg;
    logic signed [61:0] acc_reg;
    logic signed [31:0] pt_reg [3];
    logic signed [67:0] dacc_reg;
    logic signed [67:0] best_dot_reg;
    logic signed [31:0] best_reg [3];
    logic        [63:0] srem_reg;
    logic        [63:0] res_reg;
    logic        [34:0] rem_reg;
    logic        [33:0] nbits_reg;
    logic        [33:0] quo_reg;
    point_t             point_reg;

    // Combinational helpers
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [34:0] m [9];
    logic signed [34:0] qe [Q_PRODUCTS];
    logic signed [61:0] rot_sum;
    logic signed [41:0] rot_rnd;
    logic signed [67:0] dot_sum;
    logic        [63:0] sq_sum;
    logic        [63:0] sqrt_bit;
    logic        [63:0] sqrt_t;
    logic        [63:0] num_n;
    logic        [34:0] div_t;
    logic        [34:0] div_d;
    logic signed [36:0] off;
    logic               neg;

    assign status.zero_dir = (ad_reg[0] == 32'd0) && (ad_reg[1] == 32'd0) &&
                             (ad_reg[2] == 32'd0);
    assign status.norm_ok  = (|ad_reg[0][31:30]) || (|ad_reg[1][31:30]) ||
                             (|ad_reg[2][31:30]);
    assign result_word     = point_reg;

    // Multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul)
            MUL_Q:
            begin
                mul_a = 33'(q_reg[QA[cmd.k]]);
                mul_b = 33'(q_reg[QB[cmd.k]]);
            end
            MUL_ROT:
            begin
                mul_a = 33'(r_reg[4'(cmd.i) * 4'd3 + 4'(cmd.j)]);
                mul_b = CORNER_SEL[cmd.corner][cmd.j] ? 33'(hi_reg[cmd.j])
                                                      : 33'(lo_reg[cmd.j]);
            end
            MUL_DOT:
            begin
                mul_a = 33'(dir_reg[cmd.i]);
                mul_b = 33'(pt_reg[cmd.i]);
            end
            MUL_SQ:
            begin
                mul_a = $signed({1'b0, ad_reg[cmd.i]});
                mul_b = $signed({1'b0, ad_reg[cmd.i]});
            end
            MUL_NUM:
            begin
                mul_a = $signed({1'b0, ab_reg});
                mul_b = $signed({1'b0, ad_reg[cmd.i]});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Rotation matrix entries from the quaternion products
    always_comb
    begin
        for (int p = 0; p < Q_PRODUCTS; p++)
        begin
            qe[p] = 35'(qp_reg[p]);
        end
        m[0] = qe[0] + qe[1] - qe[2] - qe[3];
        m[1] = (qe[4] - qe[5]) <<< 1;
        m[2] = (qe[6] + qe[7]) <<< 1;
        m[3] = (qe[4] + qe[5]) <<< 1;
        m[4] = qe[0] - qe[1] + qe[2] - qe[3];
        m[5] = (qe[8] - qe[9]) <<< 1;
        m[6] = (qe[6] - qe[7]) <<< 1;
        m[7] = (qe[8] + qe[9]) <<< 1;
        m[8] = qe[0] - qe[1] - qe[2] + qe[3];
    end

    // Accumulations and iteration steps
    always_comb
    begin
        rot_sum  = ((cmd_d_reg.j == 2'd0) ? 62'sd0 : acc_reg) + 62'(prod_reg);
        rot_rnd  = 42'((rot_sum + 62'sd524288) >>> 20);
        dot_sum  = ((cmd_d_reg.i == 2'd0) ? 68'sd0 : dacc_reg) + 68'(prod_reg);
        sq_sum   = ((cmd_d_reg.i == 2'd0) ? 64'd0 : srem_reg) + prod_reg[63:0];
        sqrt_bit = 64'd1 << {cmd.sqrt_k, 1'b0};
        sqrt_t   = res_reg + sqrt_bit;
        num_n    = {prod_reg[62:0], 1'b0} + {32'd0, res_reg[31:0]};
        div_t    = {rem_reg[33:0], nbits_reg[33]};
        div_d    = {2'b00, res_reg[31:0], 1'b0};
        neg      = bias_neg_reg != dir_reg[cmd.i][31];
        off      = neg ? -$signed({3'b000, quo_reg}) : $signed({3'b000, quo_reg});
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                lo_reg[a] <= '0;
                hi_reg[a] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_X: lo_reg[0] <= cfg_data;
                CFG_MIN_Y: lo_reg[1] <= cfg_data;
                CFG_MIN_Z: lo_reg[2] <= cfg_data;
                CFG_MAX_X: hi_reg[0] <= cfg_data;
                CFG_MAX_Y: hi_reg[1] <= cfg_data;
                CFG_MAX_Z: hi_reg[2] <= cfg_data;
                default:   ;
            endcase
        end
    end

    // Delayed command for the consuming stage of the multiplier
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_d_reg <= '0;
        end
        else
        begin
            cmd_d_reg <= cmd;
        end
    end

    // Shared multiplier
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // Query capture and normalising shift
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dir_reg[0]   <= query_word.dir_x;
            dir_reg[1]   <= query_word.dir_y;
            dir_reg[2]   <= query_word.dir_z;
            pos_reg[0]   <= query_word.pos_x;
            pos_reg[1]   <= query_word.pos_y;
            pos_reg[2]   <= query_word.pos_z;
            q_reg[0]     <= query_word.quat_w;
            q_reg[1]     <= query_word.quat_x;
            q_reg[2]     <= query_word.quat_y;
            q_reg[3]     <= query_word.quat_z;
            bias_neg_reg <= query_word.bias[31];
            ab_reg       <= query_word.bias[31] ? 32'(-query_word.bias)
                                                : 32'(query_word.bias);
            ad_reg[0]    <= query_word.dir_x[31] ? 32'(-query_word.dir_x)
                                                 : 32'(query_word.dir_x);
            ad_reg[1]    <= query_word.dir_y[31] ? 32'(-query_word.dir_y)
                                                 : 32'(query_word.dir_y);
            ad_reg[2]    <= query_word.dir_z[31] ? 32'(-query_word.dir_z)
                                                 : 32'(query_word.dir_z);
        end
        else if (cmd.shift)
        begin
            for (int a = 0; a < 3; a++)
            begin
                ad_reg[a] <= ad_reg[a] << 1;
            end
        end
    end

    // Matrix rounding to Q20
    always_ff @(posedge clk)
    begin
        if (cmd.comb)
        begin
            for (int e = 0; e < 9; e++)
            begin
                r_reg[e] <= 27'((m[e] + 35'sd128) >>> 8);
            end
        end
    end

    // Consumption of products (quaternion terms, corners, dot products) and offset apply
    always_ff @(posedge clk)
    begin
        case (cmd_d_reg.mul)
            MUL_Q:
            begin
                qp_reg[cmd_d_reg.k] <= prod_reg[31:0];
            end
            MUL_ROT:
            begin
                acc_reg <= rot_sum;
                if (cmd_d_reg.j == 2'd2)
                begin
                    pt_reg[cmd_d_reg.i] <= sat32(48'(rot_rnd) + 48'(pos_reg[cmd_d_reg.i]));
                end
            end
            MUL_DOT:
            begin
                dacc_reg <= dot_sum;
                // Strictly greater keeps the earliest corner on ties
                if (cmd_d_reg.i == 2'd2 &&
                    (cmd_d_reg.corner == 3'd0 || dot_sum > best_dot_reg))
                begin
                    best_dot_reg <= dot_sum;
                    best_reg     <= pt_reg;
                end
            end
            default:
            begin
                if (cmd.apply)
                begin
                    best_reg[cmd.i] <= sat32(48'(best_reg[cmd.i]) + 48'(off));
                end
            end
        endcase
    end

    // Sum of squares and integer square root
    always_ff @(posedge clk)
    begin
        if (cmd_d_reg.mul == MUL_SQ)
        begin
            srem_reg <= sq_sum;
            res_reg  <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            if (srem_reg >= sqrt_t)
            begin
                srem_reg <= srem_reg - sqrt_t;
                res_reg  <= (res_reg >> 1) + sqrt_bit;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
        end
    end

    // Rounded division of bias times component by the length
    always_ff @(posedge clk)
    begin
        if (cmd_d_reg.mul == MUL_NUM)
        begin
            rem_reg   <= {5'd0, num_n[63:34]};
            nbits_reg <= num_n[33:0];
            quo_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            nbits_reg <= nbits_reg << 1;
            if (div_t >= div_d)
            begin
                rem_reg <= div_t - div_d;
                quo_reg <= {quo_reg[32:0], 1'b1};
            end
            else
            begin
                rem_reg <= div_t;
                quo_reg <= {quo_reg[32:0], 1'b0};
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            point_reg.point_x <= best_reg[0];
            point_reg.point_y <= best_reg[1];
            point_reg.point_z <= best_reg[2];
        end
    end

endmodule

@@ rtl/box_support_point.sv @@
// Sequence from the accepting edge to the result word: the shared 33x33 multiplier forms
// the 10 quaternion terms, then rotates and dots the 8 corners; a normalising shift, a
// square root and three division passes follow (a zero direction skips them). One word
// at a time: no new query is taken until the result is emitted, which waits on a stalled
// earlier result. Reset (rst_n, asynchronous, active low) clears the box registers to
// zero and returns the sequencer to idle, no result.
module box_support_point
    import bsp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    bsp_query_if.sink     query,
    bsp_result_if.source  result,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_data
);

    bsp_cmd_t    cmd;
    bsp_status_t status;
    query_t      query_word;
    point_t      result_word;

    // Pack the query payload
    assign query_word.dir_x  = query.dir_x;
    assign query_word.dir_y  = query.dir_y;
    assign query_word.dir_z  = query.dir_z;
    assign query_word.pos_x  = query.pos_x;
    assign query_word.pos_y  = query.pos_y;
    assign query_word.pos_z  = query.pos_z;
    assign query_word.quat_w = query.quat_w;
    assign query_word.quat_x = query.quat_x;
    assign query_word.quat_y = query.quat_y;
    assign query_word.quat_z = query.quat_z;
    assign query_word.bias   = query.bias;

    // Unpack the result payload
    assign result.point_x = result_word.point_x;
    assign result.point_y = result_word.point_y;
    assign result.point_z = result_word.point_z;

    bsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (query.valid),
        .in_ready  (query.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    bsp_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .query_word  (query_word),
        .cmd         (cmd),
        .status      (status),
        .result_word (result_word)
    );

endmodule

@@ rtl/bsp_checker.sv @@
// Port-level checks of the box support point block and their binding.
module bsp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] point_x,
    input logic [31:0] point_y,
    input logic [31:0] point_z
);

    // A stalled result word holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid &&
            $stable(point_x) && $stable(point_y) && $stable(point_z))
        else $error("stalled result word changed");

    // Only one query is in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("query taken while busy");

    // A result cannot appear straight after a query is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared too early");

    // No result is offered while the block idles without a fresh word
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && !in_valid && !out_valid |=> !out_valid)
        else $error("result appeared with no query");

endmodule

bind box_support_point bsp_checker u_bsp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (query.valid),
    .in_ready  (query.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .point_x   (result.point_x),
    .point_y   (result.point_y),
    .point_z   (result.point_z)
);
